/* src/cordic_polar_cartesian_converter_assert.svh */
// assertion macros for the cordic polar/cartesian converter
`ifndef CORDIC_POLAR_CARTESIAN_CONVERTER_ASSERT_SVH
`define CORDIC_POLAR_CARTESIAN_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
`define CPC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cpc assertion failed");
`define CPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cpc assertion failed");
`else
`define CPC_ASSERT_SAME(label, clk, rst, ante, cons)
`define CPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/cpc_pkg.sv */
`default_nettype none
package cpc_pkg;

   localparam int COORD_WIDTH   = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int GUARD_BITS    = 8;
   localparam int ANGLE_WIDTH   = 16;
   localparam int PHASE_WIDTH   = 32;
   localparam int DATA_WIDTH    = COORD_WIDTH + GUARD_BITS + 3;
   localparam int MAG_WIDTH     = DATA_WIDTH - 1;
   localparam int GAIN_WIDTH    = 32;
   localparam int PROD_WIDTH    = MAG_WIDTH + GAIN_WIDTH;
   localparam int SCALED_WIDTH  = MAG_WIDTH + 1;
   localparam int RES_WIDTH     = SCALED_WIDTH - GUARD_BITS;
   localparam int STAGE_WIDTH   = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

   localparam logic [GAIN_WIDTH-1:0]  GAIN          = 32'h9B74EDA8;
   localparam logic [PHASE_WIDTH-1:0] PHASE_QUARTER = 32'h4000_0000;
   localparam logic [PHASE_WIDTH-1:0] PHASE_HALF    = 32'h8000_0000;
   localparam logic [PHASE_WIDTH-1:0] PHASE_3QUART  = 32'hC000_0000;
   localparam logic [PHASE_WIDTH-1:0] PHASE_ROUND   = 32'h0000_8000;

   localparam logic [PHASE_WIDTH-1:0] ATAN_TABLE [0:31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef enum logic {
      CMD_TO_POLAR = 1'b0,
      CMD_TO_CART  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                       cmd;
      logic                          origin;
      logic signed [DATA_WIDTH-1:0]  x;
      logic signed [DATA_WIDTH-1:0]  y;
      logic [PHASE_WIDTH-1:0]        z;
   } stage_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic                    origin;
      logic                    neg_x;
      logic                    neg_y;
      logic [PROD_WIDTH-1:0]   prod_x;
      logic [PROD_WIDTH-1:0]   prod_y;
      logic [ANGLE_WIDTH-1:0]  angle;
   } prod_type;

endpackage
`default_nettype wire

/* src/cordic_polar_cartesian_converter.sv */
`default_nettype none
// Cartesian/polar converter built as an unrolled CORDIC pipeline. req_cmd low converts
// (x, y) to radius and atan2 angle; high converts (radius, angle) to x and y. Angles are
// in units of pi/32768. The pipeline takes one request per clock unless held up by a
// full pipeline under low rsp_ready, and passes each through one input mapping stage,
// one micro-rotation cell per stage, a gain multiply stage and a round/saturate stage
// that is the output register. Every stage has its own valid bit and passes a request
// on as soon as the next stage is free, so gaps close up while rsp_ready is low.
`include "cordic_polar_cartesian_converter_assert.svh"
module cordic_polar_cartesian_converter (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_cmd,
   input  logic signed [cpc_pkg::COORD_WIDTH-1:0]  req_x_in,
   input  logic signed [cpc_pkg::COORD_WIDTH-1:0]  req_y_in,
   input  logic [cpc_pkg::COORD_WIDTH-1:0]         req_radius_in,
   input  logic signed [cpc_pkg::ANGLE_WIDTH-1:0]  req_angle_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [cpc_pkg::COORD_WIDTH:0]    rsp_x_out,
   output logic signed [cpc_pkg::COORD_WIDTH:0]    rsp_y_out,
   output logic [cpc_pkg::COORD_WIDTH-1:0]         rsp_radius_out,
   output logic signed [cpc_pkg::ANGLE_WIDTH-1:0]  rsp_angle_out
);

   localparam int N  = cpc_pkg::CORDIC_STAGES;
   localparam int CW = cpc_pkg::COORD_WIDTH;
   localparam logic signed [CW:0] XY_MIN = {1'b1, {CW{1'b0}}};

   logic                  chain_valid [0:N];
   logic                  chain_ready [0:N];
   cpc_pkg::stage_type    chain_data  [0:N];

   cpc_pre u_pre (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_cmd    (req_cmd),
      .in_x      (req_x_in),
      .in_y      (req_y_in),
      .in_radius (req_radius_in),
      .in_angle  (req_angle_in),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      cpc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (cpc_pkg::STAGE_WIDTH'(i)),
         .atan      (cpc_pkg::ATAN_TABLE[i]),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   cpc_post u_post (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[N]),
      .in_ready   (chain_ready[N]),
      .in_data    (chain_data[N]),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_x      (rsp_x_out),
      .out_y      (rsp_y_out),
      .out_radius (rsp_radius_out),
      .out_angle  (rsp_angle_out)
   );

   `CPC_ASSERT_NEXT(a_accept_loads, clock, reset, req_valid && req_ready, chain_valid[0])
   `CPC_ASSERT_SAME(a_unused_zero, clock, reset, rsp_valid && (rsp_radius_out != '0 || rsp_angle_out != '0), rsp_x_out == '0 && rsp_y_out == '0)
   `CPC_ASSERT_SAME(a_xy_range, clock, reset, rsp_valid, rsp_x_out != XY_MIN && rsp_y_out != XY_MIN)

endmodule
`default_nettype wire

/* src/cpc_pre.sv */
`default_nettype none
module cpc_pre (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic                                 in_cmd,
   input  logic signed [cpc_pkg::COORD_WIDTH-1:0] in_x,
   input  logic signed [cpc_pkg::COORD_WIDTH-1:0] in_y,
   input  logic [cpc_pkg::COORD_WIDTH-1:0]      in_radius,
   input  logic signed [cpc_pkg::ANGLE_WIDTH-1:0] in_angle,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output cpc_pkg::stage_type                   out_data
);

   localparam int DW = cpc_pkg::DATA_WIDTH;
   localparam int CW = cpc_pkg::COORD_WIDTH;
   localparam int PW = cpc_pkg::PHASE_WIDTH;
   localparam int AW = cpc_pkg::ANGLE_WIDTH;

   logic                    valid_ff;
   cpc_pkg::stage_type      data_ff;
   cpc_pkg::stage_type      data_in;
   logic signed [DW-1:0]    x_ext;
   logic signed [DW-1:0]    y_ext;
   logic signed [DW-1:0]    r_ext;
   logic [PW-1:0]           phase;
   logic                    flip;

   assign in_ready = ~valid_ff | out_ready;

   always_comb begin
      x_ext = {{(DW-CW){in_x[CW-1]}}, in_x} <<< cpc_pkg::GUARD_BITS;
      y_ext = {{(DW-CW){in_y[CW-1]}}, in_y} <<< cpc_pkg::GUARD_BITS;
      r_ext = {{(DW-CW){1'b0}}, in_radius} <<< cpc_pkg::GUARD_BITS;
      phase = {in_angle, {(PW-AW){1'b0}}};
      flip  = (phase > cpc_pkg::PHASE_QUARTER) && (phase < cpc_pkg::PHASE_3QUART);
      data_in.cmd    = cpc_pkg::cmd_type'(in_cmd);
      data_in.origin = 1'b0;
      data_in.x      = '0;
      data_in.y      = '0;
      data_in.z      = '0;
      case (cpc_pkg::cmd_type'(in_cmd))
         cpc_pkg::CMD_TO_POLAR: begin
            data_in.origin = (in_x == '0) && (in_y == '0);
            if (in_x[CW-1]) begin
               data_in.x = -x_ext;
               data_in.y = -y_ext;
               data_in.z = cpc_pkg::PHASE_HALF;
            end else begin
               data_in.x = x_ext;
               data_in.y = y_ext;
            end
         end
         cpc_pkg::CMD_TO_CART: begin
            if (flip) begin
               data_in.x = -r_ext;
               data_in.z = phase - cpc_pkg::PHASE_HALF;
            end else begin
               data_in.x = r_ext;
               data_in.z = phase;
            end
         end
         default: begin
            data_in.x = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

/* src/cpc_cell.sv */
`default_nettype none
module cpc_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [cpc_pkg::STAGE_WIDTH-1:0]   shift,
   input  logic [cpc_pkg::PHASE_WIDTH-1:0]   atan,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  cpc_pkg::stage_type                in_data,
   output logic                              out_valid,
   input  logic                              out_ready,
   output cpc_pkg::stage_type                out_data
);

   localparam int DW = cpc_pkg::DATA_WIDTH;
   localparam int PW = cpc_pkg::PHASE_WIDTH;

   logic                  valid_ff;
   cpc_pkg::stage_type    data_ff;
   cpc_pkg::stage_type    data_in;
   logic signed [DW-1:0]  x_shift;
   logic signed [DW-1:0]  y_shift;
   logic                  clockwise;

   assign in_ready = ~valid_ff | out_ready;

   // rotation steers on the residual phase, vectoring on the sign of y
   always_comb begin
      x_shift   = in_data.x >>> shift;
      y_shift   = in_data.y >>> shift;
      clockwise = (in_data.cmd == cpc_pkg::CMD_TO_CART) ? in_data.z[PW-1]
                                                         : ~in_data.y[DW-1];
      data_in = in_data;
      if (clockwise) begin
         data_in.x = in_data.x + y_shift;
         data_in.y = in_data.y - x_shift;
         data_in.z = in_data.z + atan;
      end else begin
         data_in.x = in_data.x - y_shift;
         data_in.y = in_data.y + x_shift;
         data_in.z = in_data.z - atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

/* src/cpc_post.sv */
`default_nettype none
module cpc_post (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  cpc_pkg::stage_type                     in_data,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic signed [cpc_pkg::COORD_WIDTH:0]   out_x,
   output logic signed [cpc_pkg::COORD_WIDTH:0]   out_y,
   output logic [cpc_pkg::COORD_WIDTH-1:0]        out_radius,
   output logic signed [cpc_pkg::ANGLE_WIDTH-1:0] out_angle
);

   localparam int DW  = cpc_pkg::DATA_WIDTH;
   localparam int CW  = cpc_pkg::COORD_WIDTH;
   localparam int MW  = cpc_pkg::MAG_WIDTH;
   localparam int PRW = cpc_pkg::PROD_WIDTH;
   localparam int SW  = cpc_pkg::SCALED_WIDTH;
   localparam int RW  = cpc_pkg::RES_WIDTH;
   localparam int GW  = cpc_pkg::GAIN_WIDTH;
   localparam int PW  = cpc_pkg::PHASE_WIDTH;
   localparam int AW  = cpc_pkg::ANGLE_WIDTH;
   localparam logic [RW-1:0] LIMIT = RW'({CW{1'b1}});

   // multiply stage
   logic                  mul_valid_ff;
   cpc_pkg::prod_type     mul_ff;
   cpc_pkg::prod_type     mul_in;
   logic                  mul_ready;
   logic [MW-1:0]         mag_x;
   logic [MW-1:0]         mag_y;
   logic [PW-1:0]         phase_round;

   // round and saturate stage
   logic                  res_valid_ff;
   logic signed [CW:0]    x_ff;
   logic signed [CW:0]    y_ff;
   logic [CW-1:0]         radius_ff;
   logic [AW-1:0]         angle_ff;
   logic signed [CW:0]    x_in;
   logic signed [CW:0]    y_in;
   logic [CW-1:0]         radius_in;
   logic [AW-1:0]         angle_in;
   logic [SW-1:0]         sum_x;
   logic [SW-1:0]         sum_y;
   logic [RW-1:0]         scaled_x;
   logic [RW-1:0]         scaled_y;
   logic [CW-1:0]         sat_x;
   logic [CW-1:0]         sat_y;

   assign in_ready  = ~mul_valid_ff | mul_ready;
   assign mul_ready = ~res_valid_ff | out_ready;

   always_comb begin
      mul_in.cmd    = in_data.cmd;
      mul_in.origin = in_data.origin;
      mul_in.neg_x  = in_data.x[DW-1];
      mul_in.neg_y  = in_data.y[DW-1];
      mag_x = in_data.x[DW-1] ? MW'(-in_data.x) : MW'(in_data.x);
      mag_y = in_data.y[DW-1] ? MW'(-in_data.y) : MW'(in_data.y);
      if (in_data.cmd == cpc_pkg::CMD_TO_POLAR && in_data.x[DW-1]) begin
         mag_x = '0;
      end
      mul_in.prod_x = PRW'(mag_x) * PRW'(cpc_pkg::GAIN);
      mul_in.prod_y = PRW'(mag_y) * PRW'(cpc_pkg::GAIN);
      phase_round   = in_data.z + cpc_pkg::PHASE_ROUND;
      mul_in.angle  = phase_round[PW-1 -: AW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (in_ready) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         mul_ff <= mul_in;
      end
   end

   always_comb begin
      sum_x    = SW'(mul_ff.prod_x[PRW-1:GW]) + SW'(1 << (cpc_pkg::GUARD_BITS - 1));
      sum_y    = SW'(mul_ff.prod_y[PRW-1:GW]) + SW'(1 << (cpc_pkg::GUARD_BITS - 1));
      scaled_x = sum_x[SW-1:cpc_pkg::GUARD_BITS];
      scaled_y = sum_y[SW-1:cpc_pkg::GUARD_BITS];
      sat_x    = (scaled_x > LIMIT) ? {CW{1'b1}} : scaled_x[CW-1:0];
      sat_y    = (scaled_y > LIMIT) ? {CW{1'b1}} : scaled_y[CW-1:0];
      x_in      = '0;
      y_in      = '0;
      radius_in = '0;
      angle_in  = '0;
      case (mul_ff.cmd)
         cpc_pkg::CMD_TO_POLAR: begin
            if (!mul_ff.origin) begin
               radius_in = sat_x;
               angle_in  = mul_ff.angle;
            end
         end
         cpc_pkg::CMD_TO_CART: begin
            x_in = mul_ff.neg_x ? -{1'b0, sat_x} : {1'b0, sat_x};
            y_in = mul_ff.neg_y ? -{1'b0, sat_y} : {1'b0, sat_y};
         end
         default: begin
            x_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         res_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && mul_valid_ff) begin
         x_ff      <= x_in;
         y_ff      <= y_in;
         radius_ff <= radius_in;
         angle_ff  <= angle_in;
      end
   end

   assign out_valid  = res_valid_ff;
   assign out_x      = x_ff;
   assign out_y      = y_ff;
   assign out_radius = radius_ff;
   assign out_angle  = angle_ff;

endmodule
`default_nettype wire

/* tb/cordic_polar_cartesian_converter_checker.sv */
module cordic_polar_cartesian_converter_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_ready,
   input  logic                                    req_cmd,
   input  logic signed [cpc_pkg::COORD_WIDTH-1:0]  req_x_in,
   input  logic signed [cpc_pkg::COORD_WIDTH-1:0]  req_y_in,
   input  logic [cpc_pkg::COORD_WIDTH-1:0]         req_radius_in,
   input  logic signed [cpc_pkg::ANGLE_WIDTH-1:0]  req_angle_in,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  logic signed [cpc_pkg::COORD_WIDTH:0]    rsp_x_out,
   input  logic signed [cpc_pkg::COORD_WIDTH:0]    rsp_y_out,
   input  logic [cpc_pkg::COORD_WIDTH-1:0]         rsp_radius_out,
   input  logic signed [cpc_pkg::ANGLE_WIDTH-1:0]  rsp_angle_out,
   output int                                      mismatches,
   output int                                      outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW         = cpc_pkg::COORD_WIDTH;
   localparam int AW         = cpc_pkg::ANGLE_WIDTH;
   localparam int STAGES     = cpc_pkg::CORDIC_STAGES;
   localparam int FRAC_BITS  = 8;
   localparam int REPORT_MAX = 10;

   localparam longint FRAC_SCALE           = 64'sd1 << FRAC_BITS;
   localparam longint unsigned COORD_LIM   = (64'd1 << CW) - 64'd1;
   localparam longint unsigned GAIN_Q32    = 64'h9B74_EDA8;
   localparam logic [31:0] QUARTER_TURN    = 32'h4000_0000;
   localparam logic [31:0] HALF_TURN       = 32'h8000_0000;
   localparam logic [31:0] THREE_QTR_TURN  = 32'hC000_0000;

   typedef struct {
      cpc_pkg::cmd_type         cmd;
      logic signed [CW-1:0]     x_in;
      logic signed [CW-1:0]     y_in;
      logic [CW-1:0]            radius_in;
      logic signed [AW-1:0]     angle_in;
      logic signed [CW:0]       x_out;
      logic signed [CW:0]       y_out;
      logic [CW-1:0]            radius_out;
      logic signed [AW-1:0]     angle_out;
   } conversion_type;

   conversion_type converted [$];
   conversion_type want;
   conversion_type seen;
   int fail_count = 0;

   // atan(2^-i) in units of pi/2^31
   function automatic logic [31:0] arctan(int i);
      case (i)
         0:  return 32'h20000000;  1:  return 32'h12E4051E;
         2:  return 32'h09FB385B;  3:  return 32'h051111D4;
         4:  return 32'h028B0D43;  5:  return 32'h0145D7E1;
         6:  return 32'h00A2F61E;  7:  return 32'h00517C55;
         8:  return 32'h0028BE53;  9:  return 32'h00145F2F;
         10: return 32'h000A2F98;  11: return 32'h000517CC;
         12: return 32'h00028BE6;  13: return 32'h000145F3;
         14: return 32'h0000A2FA;  15: return 32'h0000517D;
         16: return 32'h000028BE;  17: return 32'h0000145F;
         18: return 32'h00000A30;  19: return 32'h00000518;
         20: return 32'h0000028C;  21: return 32'h00000146;
         22: return 32'h000000A3;  23: return 32'h00000051;
         24: return 32'h00000029;  25: return 32'h00000014;
         26: return 32'h0000000A;  27: return 32'h00000005;
         28: return 32'h00000003;  29: return 32'h00000001;
         30: return 32'h00000001;
         default: return 32'h00000000;
      endcase
   endfunction

   // magnitude times the cordic gain, guard bits dropped with rounding
   function automatic longint unsigned gain_round(longint unsigned mag);
      longint unsigned hi;
      longint unsigned lo;
      longint unsigned prod;
      hi = mag >> 32;
      lo = mag & 64'hFFFF_FFFF;
      prod = hi * GAIN_Q32 + ((lo * GAIN_Q32) >> 32);
      return (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
   endfunction

   function automatic logic signed [CW:0] scale_coord(longint v);
      longint unsigned mag;
      logic signed [CW:0] sat;
      mag = gain_round((v < 0) ? -v : v);
      if (mag > COORD_LIM)
         mag = COORD_LIM;
      sat = $signed({1'b0, mag[CW-1:0]});
      return (v < 0) ? -sat : sat;
   endfunction

   function automatic conversion_type cordic_convert(conversion_type c);
      longint x;
      longint y;
      longint xs;
      longint ys;
      logic [31:0] z;
      logic [32:0] z_rnd;
      longint unsigned mag;
      c.x_out = '0;
      c.y_out = '0;
      c.radius_out = '0;
      c.angle_out = '0;
      if (c.cmd == cpc_pkg::CMD_TO_POLAR) begin
         if (c.x_in != '0 || c.y_in != '0) begin
            x = longint'(c.x_in);
            y = longint'(c.y_in);
            z = '0;
            // left half plane: flip the vector and start from pi
            if (x < 0) begin
               x = -x;
               y = -y;
               z = HALF_TURN;
            end
            x = x * FRAC_SCALE;
            y = y * FRAC_SCALE;
            for (int i = 0; i < STAGES; i++) begin
               xs = x >>> i;
               ys = y >>> i;
               if (y >= 0) begin
                  x = x + ys;
                  y = y - xs;
                  z = z + arctan(i);
               end else begin
                  x = x - ys;
                  y = y + xs;
                  z = z - arctan(i);
               end
            end
            mag = (x < 0) ? 64'd0 : gain_round(x);
            if (mag > COORD_LIM)
               mag = COORD_LIM;
            c.radius_out = mag[CW-1:0];
            z_rnd = {1'b0, z} + 33'h0_0000_8000;
            c.angle_out = z_rnd[31:16];
         end
      end else begin
         x = longint'(c.radius_in) * FRAC_SCALE;
         y = '0;
         z = {c.angle_in, 16'h0000};
         // beyond a quarter turn: start from the negated vector
         if (z > QUARTER_TURN && z < THREE_QTR_TURN) begin
            x = -x;
            z = z - HALF_TURN;
         end
         for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (!z[31]) begin
               x = x - ys;
               y = y + xs;
               z = z - arctan(i);
            end else begin
               x = x + ys;
               y = y - xs;
               z = z + arctan(i);
            end
         end
         c.x_out = scale_coord(x);
         c.y_out = scale_coord(y);
      end
      return c;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         converted.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (converted.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("unexpected response x=%0d y=%0d r=%0d a=%0d",
                     rsp_x_out, rsp_y_out, rsp_radius_out, rsp_angle_out);
            end else begin
               want = converted.pop_front();
               if (rsp_x_out !== want.x_out || rsp_y_out !== want.y_out ||
                   rsp_radius_out !== want.radius_out ||
                   rsp_angle_out !== want.angle_out) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX) begin
                     $display("mismatch cmd=%0d in x=%0d y=%0d r=%0d a=%0d",
                        want.cmd, want.x_in, want.y_in, want.radius_in, want.angle_in);
                     $display("  expected x=%0d y=%0d r=%0d a=%0d",
                        want.x_out, want.y_out, want.radius_out, want.angle_out);
                     $display("  got x=%0d y=%0d r=%0d a=%0d",
                        rsp_x_out, rsp_y_out, rsp_radius_out, rsp_angle_out);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            seen.cmd = cpc_pkg::cmd_type'(req_cmd);
            seen.x_in = req_x_in;
            seen.y_in = req_y_in;
            seen.radius_in = req_radius_in;
            seen.angle_in = req_angle_in;
            converted.push_back(cordic_convert(seen));
         end
         outstanding <= converted.size();
      end
      mismatches <= fail_count;
   end

endmodule

/* tb/cordic_polar_cartesian_converter_tb.sv */
module cordic_polar_cartesian_converter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW              = cpc_pkg::COORD_WIDTH;
   localparam int AW              = cpc_pkg::ANGLE_WIDTH;
   localparam int RANDOM_REQUESTS = 1200;
   localparam int IDLE_LIMIT      = 4000;
   localparam int HOLD_CYCLES     = 200;
   localparam int DRAIN_CYCLES    = 40;

   localparam logic [CW-1:0] RADIUS_MAX        = CW'(46341);
   localparam logic signed [CW-1:0] COORD_MIN  = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] COORD_MAX  = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] COORD_ONE  = CW'(1);
   localparam logic signed [CW-1:0] COORD_NEG  = CW'(-1);
   localparam logic signed [AW-1:0] ANGLE_MIN  = {1'b1, {(AW-1){1'b0}}};
   localparam logic signed [AW-1:0] ANGLE_MAX  = {1'b0, {(AW-1){1'b1}}};
   localparam logic signed [AW-1:0] ANGLE_QTR  = {2'b01, {(AW-2){1'b0}}};
   localparam logic signed [AW-1:0] ANGLE_ONE  = AW'(1);

   typedef struct {
      cpc_pkg::cmd_type      cmd;
      logic signed [CW-1:0]  x;
      logic signed [CW-1:0]  y;
      logic [CW-1:0]         radius;
      logic signed [AW-1:0]  angle;
   } request_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_cmd = 1'b0;
   logic signed [CW-1:0]    req_x_in = '0;
   logic signed [CW-1:0]    req_y_in = '0;
   logic [CW-1:0]           req_radius_in = '0;
   logic signed [AW-1:0]    req_angle_in = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [CW:0]      rsp_x_out;
   logic signed [CW:0]      rsp_y_out;
   logic [CW-1:0]           rsp_radius_out;
   logic signed [AW-1:0]    rsp_angle_out;
   int                      mismatches;
   int                      outstanding;

   request_type requests [$];
   int idle_cycles = 0;
   int rsp_seen = 0;

   cordic_polar_cartesian_converter u_dut (.*);

   cordic_polar_cartesian_converter_checker u_checker (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // every fifth stretch of 100 runs back to back
   function automatic int idle_draw(int n);
      if ((n / 100) % 5 == 4)
         return 0;
      return $urandom_range(0, 12);
   endfunction

   function automatic logic signed [CW-1:0] corner_coord();
      case ($urandom_range(0, 5))
         0: return COORD_MIN;
         1: return COORD_MIN + COORD_ONE;
         2: return COORD_NEG;
         3: return '0;
         4: return COORD_ONE;
         default: return COORD_MAX;
      endcase
   endfunction

   function automatic logic signed [CW-1:0] random_coord();
      int v;
      case ($urandom_range(0, 9))
         0, 1: v = $urandom_range(0, 127) - 64;
         2: return corner_coord();
         3: v = 0;
         default: v = $urandom;
      endcase
      return v[CW-1:0];
   endfunction

   task automatic add_to_polar(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
      request_type r;
      r.cmd = cpc_pkg::CMD_TO_POLAR;
      r.x = x;
      r.y = y;
      r.radius = CW'($urandom_range(0, RADIUS_MAX));
      r.angle = AW'($urandom);
      requests.push_back(r);
   endtask

   task automatic add_to_cart(input logic [CW-1:0] radius, input logic signed [AW-1:0] angle);
      request_type r;
      r.cmd = cpc_pkg::CMD_TO_CART;
      r.x = CW'($urandom);
      r.y = CW'($urandom);
      r.radius = radius;
      r.angle = angle;
      requests.push_back(r);
   endtask

   task automatic add_random();
      logic [CW-1:0] radius;
      int phase;
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 7))
            0: radius = CW'($urandom_range(0, 64));
            1: radius = RADIUS_MAX - CW'($urandom_range(0, 2));
            default: radius = CW'($urandom_range(0, RADIUS_MAX));
         endcase
         // near the octant boundaries now and then
         if ($urandom_range(0, 7) == 0)
            phase = $urandom_range(0, 7) * 8192 + $urandom_range(0, 2) - 1;
         else
            phase = $urandom;
         add_to_cart(radius, phase[AW-1:0]);
      end else begin
         add_to_polar(random_coord(), random_coord());
      end
   endtask

   initial begin
      add_to_polar('0, '0);
      add_to_polar(COORD_MAX, '0);
      add_to_polar(COORD_MIN, '0);
      add_to_polar('0, COORD_MAX);
      add_to_polar('0, COORD_MIN);
      add_to_polar(COORD_MIN, COORD_MIN);
      add_to_polar(COORD_MAX, COORD_MAX);
      add_to_polar(COORD_MAX, COORD_MIN);
      add_to_polar(COORD_NEG, '0);
      add_to_polar(COORD_NEG, COORD_NEG);
      add_to_polar(COORD_ONE, COORD_NEG);
      add_to_polar(COORD_MIN, COORD_ONE);
      add_to_cart('0, 16'sh1234);
      add_to_cart(RADIUS_MAX, '0);
      add_to_cart(RADIUS_MAX, ANGLE_QTR);
      add_to_cart(RADIUS_MAX, ANGLE_QTR + ANGLE_ONE);
      add_to_cart(RADIUS_MAX, -ANGLE_QTR);
      add_to_cart(RADIUS_MAX, -ANGLE_QTR - ANGLE_ONE);
      add_to_cart(RADIUS_MAX, ANGLE_MIN);
      add_to_cart(RADIUS_MAX, ANGLE_MAX);
      add_to_cart(CW'(1), ANGLE_QTR >>> 1);
      add_to_cart(RADIUS_MAX, ANGLE_QTR + (ANGLE_QTR >>> 1));
      repeat (RANDOM_REQUESTS) add_random();

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (requests[i]) begin
         int gap;
         gap = idle_draw(i);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_cmd <= requests[i].cmd;
         req_x_in <= requests[i].x;
         req_y_in <= requests[i].y;
         req_radius_in <= requests[i].radius;
         req_angle_in <= requests[i].angle;
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // response side; two long hold-offs let the pipeline fill and back up
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_seen == 250 || rsp_seen == 700)
            stall = HOLD_CYCLES;
         else
            stall = idle_draw(rsp_seen);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         rsp_seen++;
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

endmodule

/* cordic_polar_cartesian_converter.f */
+incdir+src
src/cpc_pkg.sv
src/cpc_pre.sv
src/cpc_cell.sv
src/cpc_post.sv
src/cordic_polar_cartesian_converter.sv
tb/cordic_polar_cartesian_converter_checker.sv
tb/cordic_polar_cartesian_converter_tb.sv
